// File: sv/svpwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the space vector PWM compare generator.
// No dependencies; used by svpwm_compare_values.

package svpwm_pkg;

  // Field widths of the request and result channels.
  localparam int ANGLE_W = 14;
  localparam int AMP_W   = 17;
  localparam int CMP_W   = 16;

  // Sine samples are Q15 values below sin(60 deg) * 2^15, so they fit in 15 bits.
  localparam int SINE_W  = 15;
  localparam int Q_SHIFT = 15;

  localparam int unsigned DUTY_RESET = 16'd4000;

  localparam real PI = 3.14159265358979323846;

  // Space vector sector numbers as they appear on the sector output.
  typedef enum logic [2:0] {
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5,
    SECTOR_6 = 3'd6
  } sector_t;

endpackage

// File: sv/svpwm_compare_values.sv
`timescale 1ns / 1ps
// Space vector PWM compare generator: angle and amplitude in, three compare values out.
// Depends on svpwm_pkg for field widths and the sector type.

// svpwm_compare_values accepts one request per clock while in_stall is low, and returns
// one result per request. Each request moves through the stage 1, stage 2 and output
// registers; the output register holds a result while out_stall is high. The first stage
// wraps and clamps the angle, finds the 60-degree sector and clamps the amplitude, and
// reads the two sine samples from an elaboration-time Q15 sine ROM of FULL_TURN/6 + 1
// entries into registers. The second stage forms the two active times with one
// 15 x 16 bit multiply each. The third stage splits the zero time, stacks the three
// compares in sector order, saturates them to 16 bits and holds them in the output
// register. Each stage advances whenever the stage after it is empty or advancing, so
// a stalled result does not block requests already in flight from filling the gaps
// behind it. full_duty_count is written through the cfg channel, which is always ready;
// it is read live by the pipeline, so it should be written only while no request is
// in flight. It resets to 4000. FULL_TURN sets the angle units per revolution and the
// size of the sine ROM.

module svpwm_compare_values #(
  parameter int FULL_TURN = 4096
) (
  input  logic                            clk,
  input  logic                            rst,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     cfg_data,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [svpwm_pkg::ANGLE_W-1:0] electrical_angle,
  input  logic signed [svpwm_pkg::AMP_W-1:0]   amplitude,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [svpwm_pkg::CMP_W-1:0]     compare_a,
  output logic [svpwm_pkg::CMP_W-1:0]     compare_b,
  output logic [svpwm_pkg::CMP_W-1:0]     compare_c,
  output logic [2:0]                      sector
);

  localparam int BAND = FULL_TURN / 6;
  // Unsigned width of an angle inside the turn, and of a sine ROM index.
  localparam int AW = $clog2(FULL_TURN);
  localparam int RW = $clog2(BAND + 1);
  // Signed width that holds both the input angle and FULL_TURN itself.
  localparam int TW = $clog2(FULL_TURN + 1) + 1;
  localparam int WW = ((TW > svpwm_pkg::ANGLE_W) ? TW : svpwm_pkg::ANGLE_W) + 1;

  localparam int START_2 = (1 * FULL_TURN) / 6;
  localparam int START_3 = (2 * FULL_TURN) / 6;
  localparam int START_4 = (3 * FULL_TURN) / 6;
  localparam int START_5 = (4 * FULL_TURN) / 6;
  localparam int START_6 = (5 * FULL_TURN) / 6;

  localparam logic signed [WW-1:0] TURN_S = WW'(FULL_TURN);
  localparam logic signed [WW-1:0] LAST_S = WW'(FULL_TURN - 1);

  localparam int SW = svpwm_pkg::SINE_W;
  localparam int CW = svpwm_pkg::CMP_W;
  localparam int PW = SW + CW;

  typedef logic [SW-1:0] rom_t [BAND + 1];

  // Q15 sine over one band, rounded to nearest.
  function automatic rom_t build_sine_rom();
    rom_t rom;
    real  x;
    for (int i = 0; i <= BAND; i++) begin
      x = $sin(2.0 * svpwm_pkg::PI * i / FULL_TURN) * 32768.0;
      rom[i] = SW'($rtoi(x + 0.5));
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

  function automatic logic [CW-1:0] sat16(logic signed [CW+2:0] v);
    logic [CW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b000, {CW{1'b1}}})) begin
      r = '1;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Configuration register.
  logic [CW-1:0] full_duty_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_duty_count <= CW'(svpwm_pkg::DUTY_RESET);
    end else if (cfg_valid && cfg_ready) begin
      full_duty_count <= cfg_data;
    end
  end

  // Stage handshake: a stage loads when it is empty or its contents move on.
  logic v1, v2;
  logic ld1, ld2, ld3;

  assign ld3      = !out_valid || !out_stall;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_stall = !ld1;

  // Angle wrap and clamp, sector search, amplitude clamp.
  logic signed [WW-1:0] ang_ext, ang_wrap;
  logic [AW-1:0]        ang_idx, band_base, off_full;
  logic [RW-1:0]        off_idx, s1_idx;
  svpwm_pkg::sector_t   sector_s;
  logic [CW-1:0]        amp_s;

  always_comb begin
    ang_ext = WW'(electrical_angle);
    if (ang_ext >= TURN_S) begin
      ang_wrap = ang_ext - TURN_S;
    end else if (ang_ext < 0) begin
      ang_wrap = ang_ext + TURN_S;
    end else begin
      ang_wrap = ang_ext;
    end
    if (ang_wrap < 0) begin
      ang_idx = '0;
    end else if (ang_wrap > LAST_S) begin
      ang_idx = AW'(FULL_TURN - 1);
    end else begin
      ang_idx = ang_wrap[AW-1:0];
    end

    if (ang_idx >= AW'(START_6)) begin
      sector_s  = svpwm_pkg::SECTOR_6;
      band_base = AW'(START_6);
    end else if (ang_idx >= AW'(START_5)) begin
      sector_s  = svpwm_pkg::SECTOR_5;
      band_base = AW'(START_5);
    end else if (ang_idx >= AW'(START_4)) begin
      sector_s  = svpwm_pkg::SECTOR_4;
      band_base = AW'(START_4);
    end else if (ang_idx >= AW'(START_3)) begin
      sector_s  = svpwm_pkg::SECTOR_3;
      band_base = AW'(START_3);
    end else if (ang_idx >= AW'(START_2)) begin
      sector_s  = svpwm_pkg::SECTOR_2;
      band_base = AW'(START_2);
    end else begin
      sector_s  = svpwm_pkg::SECTOR_1;
      band_base = '0;
    end

    // A band is at most BAND + 1 counts wide, so the offset never exceeds BAND.
    off_full = ang_idx - band_base;
    off_idx  = off_full[RW-1:0];
    s1_idx   = RW'(BAND) - off_idx;

    if (amplitude < 0) begin
      amp_s = '0;
    end else if (amplitude > $signed({1'b0, full_duty_count})) begin
      amp_s = full_duty_count;
    end else begin
      amp_s = amplitude[CW-1:0];
    end
  end

  // Stage 1: sine ROM read data and the clamped amplitude.
  logic [SW-1:0]      sine_k, sine_k1;
  logic [CW-1:0]      amp1;
  svpwm_pkg::sector_t sector1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      sine_k  <= SINE_ROM[s1_idx];
      sine_k1 <= SINE_ROM[off_idx];
      amp1    <= amp_s;
      sector1 <= sector_s;
    end
  end

  // Stage 2: the two active times.
  logic [PW-1:0]      prod_k, prod_k1;
  logic [CW-1:0]      tk, tk1;
  svpwm_pkg::sector_t sector2;

  assign prod_k  = PW'(sine_k) * PW'(amp1);
  assign prod_k1 = PW'(sine_k1) * PW'(amp1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      tk      <= prod_k[svpwm_pkg::Q_SHIFT +: CW];
      tk1     <= prod_k1[svpwm_pkg::Q_SHIFT +: CW];
      sector2 <= sector1;
    end
  end

  // Stage 3: zero time split and sector-ordered stacking. The rounded sines can
  // push tk + tk1 past the duty count, so t0 may be negative; sat16 floors the compares at zero.
  logic signed [CW+1:0] t0;
  logic signed [CW+2:0] h, tk_s, tk1_s, a_s, b_s, c_s;

  always_comb begin
    t0    = $signed({2'b00, full_duty_count}) - $signed({2'b00, tk})
            - $signed({2'b00, tk1});
    h     = (CW+3)'(t0 >>> 1);
    tk_s  = $signed({3'b000, tk});
    tk1_s = $signed({3'b000, tk1});
    case (sector2)
      svpwm_pkg::SECTOR_1: begin
        c_s = h;
        b_s = c_s + tk1_s;
        a_s = b_s + tk_s;
      end
      svpwm_pkg::SECTOR_2: begin
        c_s = h;
        a_s = c_s + tk_s;
        b_s = a_s + tk1_s;
      end
      svpwm_pkg::SECTOR_3: begin
        a_s = h;
        c_s = a_s + tk1_s;
        b_s = c_s + tk_s;
      end
      svpwm_pkg::SECTOR_4: begin
        a_s = h;
        b_s = a_s + tk_s;
        c_s = b_s + tk1_s;
      end
      svpwm_pkg::SECTOR_5: begin
        b_s = h;
        a_s = b_s + tk1_s;
        c_s = a_s + tk_s;
      end
      default: begin
        b_s = h;
        c_s = b_s + tk_s;
        a_s = c_s + tk1_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      compare_a <= sat16(a_s);
      compare_b <= sat16(b_s);
      compare_c <= sat16(c_s);
      sector    <= sector2;
    end
  end

endmodule
